// ===== src/jes_pkg.sv =====
// ----------------------------------------------------------------------------
// jes_pkg: shared types and constants of the joystick expo shaper
// field widths, fixed-point constants, csr register indexes and lane result
// ----------------------------------------------------------------------------
package jes_pkg;

   localparam int DB_W   = 9;   // deadband register width
   localparam int EXPO_W = 15;  // expo weight register width
   localparam int MOVE_W = 8;   // max move register width
   localparam int FRAC_W = 16;  // shaped fraction, signed q2.14
   localparam int AMT_W  = 9;   // move amount, signed
   localparam int MAG_W  = 15;  // magnitude of a shaped fraction
   localparam int CSR_W  = 15;  // csr data width, widest register
   localparam int IDX_W  = 2;   // csr index width

   localparam int Q_FRAC = 14;
   localparam logic [EXPO_W-1:0] Q_ONE = EXPO_W'(16384);

   // percent grid: m in -100..100, p = m / 100
   localparam logic [7:0]  PCT_SPAN  = 8'd100;
   localparam logic [7:0]  PCT_RANGE = 8'd200;
   localparam logic [13:0] PCT_SQ    = 14'd10000;
   // q_one * 100^2
   localparam logic [28:0] SCALE_NUM = 29'd163840000;

   // division by 100^3 = 2^6 * 15625: shift, then reciprocal multiply
   localparam int DIV_SHIFT = 6;
   localparam int RECIP_SH  = 42;
   localparam logic [63:0] RECIP_FULL = ((64'd1 << RECIP_SH) + 64'd15624) / 64'd15625;
   localparam logic [28:0] RECIP = RECIP_FULL[28:0];

   // csr register indexes
   localparam logic [IDX_W-1:0] CSR_X_DEADBAND  = 2'd0;
   localparam logic [IDX_W-1:0] CSR_Y_DEADBAND  = 2'd1;
   localparam logic [IDX_W-1:0] CSR_EXPO_WEIGHT = 2'd2;
   localparam logic [IDX_W-1:0] CSR_MAX_MOVE    = 2'd3;

   // shaped value of one axis, sign and magnitude
   typedef struct packed {
      logic             neg;
      logic [MAG_W-1:0] mag;
   } lane_result_type;

endpackage

// ===== src/joystick_expo_shaper_unit.sv =====
// ----------------------------------------------------------------------------
// joystick_expo_shaper_unit: deadband and cubic expo shaping of a stick pair
// two axis lanes in parallel, merged into one shaped fraction and move amount
// ----------------------------------------------------------------------------
// usage
// - command channel: a sample pair (req_x_sample, req_y_sample) is taken at a
//   clock edge with start high and busy low; one beat per cycle is accepted
// - result channel: rsp_strobe marks each result for exactly one cycle, with
//   rsp_shaped_fraction (signed q2.14) and rsp_move_amount (signed)
// - pipeline: each result is registered through the six lane stages (snap,
//   percent map, square, blend, numerator, reciprocal divide) and two merge
//   stages (axis select, move scale)
// - throughput: one beat per cycle while busy is low, every stage is a plain register stage
// - csr port: csr_we writes csr_wdata into register csr_index at the edge;
//   write only with no beat in flight
// - reset: registers take their defaults (deadbands 20, expo 8192, max move
//   10), the pipeline is emptied and busy is high for one cycle
// - the receiver cannot stall, so busy never rises after reset
// ----------------------------------------------------------------------------
module joystick_expo_shaper_unit #(
   parameter int SAMPLE_BITS = 10
) (
   input  logic                              clock,
   input  logic                              reset,
   // command channel
   input  logic                              start,
   output logic                              busy,
   input  logic [SAMPLE_BITS-1:0]            req_x_sample,
   input  logic [SAMPLE_BITS-1:0]            req_y_sample,
   // result channel
   output logic                              rsp_strobe,
   output logic signed [jes_pkg::FRAC_W-1:0] rsp_shaped_fraction,
   output logic signed [jes_pkg::AMT_W-1:0]  rsp_move_amount,
   // csr write port
   input  logic                              csr_we,
   input  logic [jes_pkg::IDX_W-1:0]         csr_index,
   input  logic [jes_pkg::CSR_W-1:0]         csr_wdata
);

   // 6 lane stages + 2 merge stages
   localparam int LATENCY = 8;

   // csr registers
   logic [jes_pkg::DB_W-1:0]   x_db_ff;
   logic [jes_pkg::DB_W-1:0]   y_db_ff;
   logic [jes_pkg::EXPO_W-1:0] expo_ff;
   logic [jes_pkg::MOVE_W-1:0] max_move_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         x_db_ff     <= jes_pkg::DB_W'(20);
         y_db_ff     <= jes_pkg::DB_W'(20);
         expo_ff     <= jes_pkg::EXPO_W'(8192);
         max_move_ff <= jes_pkg::MOVE_W'(10);
      end else if (csr_we) begin
         case (csr_index)
            jes_pkg::CSR_X_DEADBAND:  x_db_ff     <= csr_wdata[jes_pkg::DB_W-1:0];
            jes_pkg::CSR_Y_DEADBAND:  y_db_ff     <= csr_wdata[jes_pkg::DB_W-1:0];
            jes_pkg::CSR_EXPO_WEIGHT: expo_ff     <= csr_wdata[jes_pkg::EXPO_W-1:0];
            jes_pkg::CSR_MAX_MOVE:    max_move_ff <= csr_wdata[jes_pkg::MOVE_W-1:0];
            default: ;
         endcase
      end
   end

   // weights above one behave as a pure cube
   logic [jes_pkg::EXPO_W-1:0] expo_sat;
   assign expo_sat = (expo_ff > jes_pkg::Q_ONE) ? jes_pkg::Q_ONE : expo_ff;

   // handshake and beat tracking
   logic               busy_ff;
   logic               accept;
   logic [LATENCY-1:0] vld_ff, vld_in;

   assign accept = start && !busy_ff;
   assign vld_in = {vld_ff[LATENCY-2:0], accept};

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b1;
         vld_ff  <= '0;
      end else begin
         busy_ff <= 1'b0;
         vld_ff  <= vld_in;
      end
   end

   // axis lanes
   jes_pkg::lane_result_type x_res, y_res;

   jes_lane #(.SAMPLE_BITS(SAMPLE_BITS)) u_lane_x (
      .clock  (clock),
      .sample (req_x_sample),
      .band   (x_db_ff),
      .expo   (expo_sat),
      .result (x_res)
   );

   jes_lane #(.SAMPLE_BITS(SAMPLE_BITS)) u_lane_y (
      .clock  (clock),
      .sample (req_y_sample),
      .band   (y_db_ff),
      .expo   (expo_sat),
      .result (y_res)
   );

   // winner select and move scaling
   jes_merge u_merge (
      .clock           (clock),
      .x_res           (x_res),
      .y_res           (y_res),
      .max_move        (max_move_ff),
      .shaped_fraction (rsp_shaped_fraction),
      .move_amount     (rsp_move_amount)
   );

   assign busy       = busy_ff;
   assign rsp_strobe = vld_ff[LATENCY-1];

   // every strobe traces back to an accepted beat
   a_strobe_from_beat : assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |-> $past(start && !busy, LATENCY))
      else $error("result strobe without an accepted beat");

   // shaped fraction stays within plus or minus one
   a_frac_range : assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |-> (rsp_shaped_fraction <= 16'sd16384 &&
                      rsp_shaped_fraction >= -16'sd16384))
      else $error("shaped fraction out of range");

   // a zero fraction moves nothing
   a_zero_move : assert property (@(posedge clock) disable iff (reset)
      (rsp_strobe && rsp_shaped_fraction == '0) |-> rsp_move_amount == '0)
      else $error("move amount without deflection");

   // move amount follows the sign of the fraction
   a_move_sign : assert property (@(posedge clock) disable iff (reset)
      (rsp_strobe && rsp_move_amount != '0) |->
         rsp_move_amount[jes_pkg::AMT_W-1] == rsp_shaped_fraction[jes_pkg::FRAC_W-1])
      else $error("move amount sign differs from fraction");

endmodule

// ===== src/jes_lane.sv =====
// ----------------------------------------------------------------------------
// jes_lane: one axis of the shaper
// deadband snap, percent mapping and cubic expo blend, six register stages
// ----------------------------------------------------------------------------
module jes_lane #(
   parameter int SAMPLE_BITS = 10
) (
   input  logic                          clock,
   input  logic [SAMPLE_BITS-1:0]        sample,
   input  logic [jes_pkg::DB_W-1:0]      band,
   input  logic [jes_pkg::EXPO_W-1:0]    expo,
   output jes_pkg::lane_result_type      result
);

   localparam int SB    = SAMPLE_BITS;
   localparam int CMP_W = (SB > jes_pkg::DB_W) ? SB : jes_pkg::DB_W;
   localparam logic [SB-1:0] CENTER = SB'((1 << (SB - 1)) - 1);
   localparam logic [SB:0]   FULL   = (SB + 1)'((1 << SB) - 1);

   // stage 1: deadband snap
   logic [SB:0]   diff;
   logic [SB-1:0] offset;
   logic [SB-1:0] snap_in, snap_ff;

   always_comb begin
      diff = {1'b0, sample} - {1'b0, CENTER};
      offset = diff[SB] ? SB'(-diff) : diff[SB-1:0];
      snap_in = (CMP_W'(offset) < CMP_W'(band)) ? CENTER : sample;
   end

   // stage 2: m = snap * 200 / full - 100, kept as sign and magnitude
   logic [SB+7:0] prod200;
   logic [7:0]    hi_part;
   logic [SB:0]   fold;
   logic [7:0]    pct;
   logic          neg2_in, neg2_ff;
   logic [6:0]    mag2_in, mag2_ff;

   always_comb begin
      prod200 = (SB + 8)'(snap_ff) * (SB + 8)'(jes_pkg::PCT_RANGE);
      hi_part = prod200[SB+7:SB];
      // x / (2^n - 1) = t + (t + r) / (2^n - 1), and t + r stays below twice full
      fold = (SB + 1)'(hi_part) + (SB + 1)'(prod200[SB-1:0]);
      pct = hi_part + ((fold >= FULL) ? 8'd1 : 8'd0);
      neg2_in = pct < jes_pkg::PCT_SPAN;
      mag2_in = neg2_in ? 7'(jes_pkg::PCT_SPAN - pct) : 7'(pct - jes_pkg::PCT_SPAN);
   end

   // stage 3: k = 100^2 - a^2
   logic [13:0] sq;
   logic [13:0] k3_in, k3_ff;
   logic        neg3_ff;
   logic [6:0]  mag3_ff;

   always_comb begin
      sq = 14'(mag2_ff) * 14'(mag2_ff);
      k3_in = jes_pkg::PCT_SQ - sq;
   end

   // stage 4: scale - e * k, the blend numerator over a
   logic [28:0] ek;
   logic [27:0] blend4_in, blend4_ff;
   logic        neg4_ff;
   logic [6:0]  mag4_ff;

   always_comb begin
      ek = 29'(expo) * 29'(k3_ff);
      blend4_in = 28'(jes_pkg::SCALE_NUM - ek);
   end

   // stage 5: numerator times a, low bits of 100^3 shifted out
   logic [34:0] num;
   logic [27:0] num5_in, num5_ff;
   logic        neg5_ff;

   always_comb begin
      num = 35'(blend4_ff) * 35'(mag4_ff);
      num5_in = num[jes_pkg::DIV_SHIFT+27:jes_pkg::DIV_SHIFT];
   end

   // stage 6: divide by 15625 through a reciprocal multiply
   logic [56:0]               quot;
   logic [jes_pkg::MAG_W-1:0] mag6_in;

   always_comb begin
      quot = 57'(num5_ff) * 57'(jes_pkg::RECIP);
      mag6_in = quot[jes_pkg::RECIP_SH+jes_pkg::MAG_W-1:jes_pkg::RECIP_SH];
   end

   jes_pkg::lane_result_type res_ff;

   always_ff @(posedge clock) begin
      snap_ff   <= snap_in;
      neg2_ff   <= neg2_in;
      mag2_ff   <= mag2_in;
      k3_ff     <= k3_in;
      neg3_ff   <= neg2_ff;
      mag3_ff   <= mag2_ff;
      blend4_ff <= blend4_in;
      neg4_ff   <= neg3_ff;
      mag4_ff   <= mag3_ff;
      num5_ff   <= num5_in;
      neg5_ff   <= neg4_ff;
      res_ff.neg <= neg5_ff;
      res_ff.mag <= mag6_in;
   end

   assign result = res_ff;

endmodule

// ===== src/jes_merge.sv =====
// ----------------------------------------------------------------------------
// jes_merge: picks the winning axis and scales it to a move amount
// two register stages: select, then max_move multiply
// ----------------------------------------------------------------------------
module jes_merge (
   input  logic                              clock,
   input  jes_pkg::lane_result_type          x_res,
   input  jes_pkg::lane_result_type          y_res,
   input  logic [jes_pkg::MOVE_W-1:0]        max_move,
   output logic signed [jes_pkg::FRAC_W-1:0] shaped_fraction,
   output logic signed [jes_pkg::AMT_W-1:0]  move_amount
);

   // stage 1: larger magnitude wins, y on a tie
   jes_pkg::lane_result_type win_in, win_ff;

   assign win_in = (x_res.mag > y_res.mag) ? x_res : y_res;

   // stage 2: truncate toward zero on the magnitude, then apply the sign
   localparam int PW = jes_pkg::MOVE_W + jes_pkg::MAG_W;

   logic [PW-1:0]                      scaled;
   logic [jes_pkg::MOVE_W-1:0]         amt_mag;
   logic signed [jes_pkg::FRAC_W-1:0]  frac_in, frac_ff;
   logic signed [jes_pkg::AMT_W-1:0]   amt_in, amt_ff;

   always_comb begin
      scaled  = PW'(max_move) * PW'(win_ff.mag);
      amt_mag = scaled[jes_pkg::Q_FRAC+jes_pkg::MOVE_W-1:jes_pkg::Q_FRAC];
      frac_in = win_ff.neg ? -$signed({1'b0, win_ff.mag}) : $signed({1'b0, win_ff.mag});
      amt_in  = win_ff.neg ? -$signed({1'b0, amt_mag}) : $signed({1'b0, amt_mag});
   end

   always_ff @(posedge clock) begin
      win_ff  <= win_in;
      frac_ff <= frac_in;
      amt_ff  <= amt_in;
   end

   assign shaped_fraction = frac_ff;
   assign move_amount     = amt_ff;

endmodule
